// ===== hw/rtl/snfcs_pkg.sv =====
// Shared types and constants for the SPI NOR command sequencer.
package snfcs_pkg;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] address;
      logic [31:0] length;
      logic [7:0]  reply_byte;
      logic        xfer_ok;
   } req_type_s_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  opcode;
      logic [25:0] flash_address;
      logic        has_address;
      logic [1:0]  data_dir;
      logic [8:0]  data_length;
      logic [2:0]  result_code;
      logic [26:0] bytes_done;
      logic        command_attempted;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [2:0]  cls;
      logic        bad_read;
      logic        bad_prog;
      logic        bad_erase;
      logic        zero_len;
      logic [31:0] address;
      logic [31:0] length;
      logic [7:0]  reply_byte;
      logic        xfer_ok;
   } item_type;

   localparam logic [2:0] CLS_READ  = 3'd0;
   localparam logic [2:0] CLS_PROG  = 3'd1;
   localparam logic [2:0] CLS_ERASE = 3'd2;
   localparam logic [2:0] CLS_DONE  = 3'd3;
   localparam logic [2:0] CLS_TICK  = 3'd4;

   localparam logic [7:0] OPC_READ  = 8'h13;
   localparam logic [7:0] OPC_PROG  = 8'h12;
   localparam logic [7:0] OPC_ERASE = 8'h21;
   localparam logic [7:0] OPC_RDSR  = 8'h05;
   localparam logic [7:0] OPC_WREN  = 8'h06;
   localparam logic [7:0] OPC_RDFSR = 8'h70;
   localparam logic [7:0] OPC_CLFSR = 8'h50;
   localparam logic [7:0] SR_WEL     = 8'h02;
   localparam logic [7:0] FSR_READY  = 8'h80;
   localparam logic [7:0] FSR_ERRORS = 8'h32;

   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_READ  = 2'd1;
   localparam logic [1:0] DIR_WRITE = 2'd2;

   localparam logic [2:0] RC_OK      = 3'd0;
   localparam logic [2:0] RC_INVALID = 3'd1;
   localparam logic [2:0] RC_PROTO   = 3'd2;
   localparam logic [2:0] RC_HWFAULT = 3'd3;
   localparam logic [2:0] RC_TIMEOUT = 3'd4;
   localparam logic [2:0] RC_BUSY    = 3'd5;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_FOREVER = 1'b1;

endpackage

// ===== hw/rtl/snfcs_front.sv =====
// Front end: accepts requests and precomputes the range and alignment checks.
module snfcs_front #(
   parameter longint CAPACITY_BYTES  = 67108864,
   parameter longint PAGE_BYTES      = 256,
   parameter longint SUBSECTOR_BYTES = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  snfcs_pkg::req_type_s_type req_data,
   output logic                     item_valid,
   input  logic                     item_stall,
   output snfcs_pkg::item_type      item_data
);
   import snfcs_pkg::*;

   localparam int PW = $clog2(PAGE_BYTES);
   localparam int SW = $clog2(SUBSECTOR_BYTES);

   logic     valid_ff, valid_in;
   item_type data_ff, data_in;
   logic [32:0] end_sum, erase_end;
   logic [32:0] page_end;

   assign req_stall = valid_ff && item_stall;

   always_comb begin
      end_sum   = {1'b0, req_data.address} + {1'b0, req_data.length};
      erase_end = {1'b0, req_data.address} + 33'(SUBSECTOR_BYTES);
      page_end  = 33'(req_data.address[PW-1:0]) + {1'b0, req_data.length};
      data_in.cls        = req_data.req_type;
      data_in.address    = req_data.address;
      data_in.length     = req_data.length;
      data_in.reply_byte = req_data.reply_byte;
      data_in.xfer_ok    = req_data.xfer_ok;
      data_in.zero_len   = (req_data.length == 32'd0);
      data_in.bad_read   = (34'(end_sum) > 34'(CAPACITY_BYTES));
      data_in.bad_prog   = data_in.zero_len ||
                           (33'(req_data.length) > 33'(PAGE_BYTES)) ||
                           (page_end > 33'(PAGE_BYTES)) ||
                           (34'(end_sum) > 34'(CAPACITY_BYTES));
      data_in.bad_erase  = (req_data.address[SW-1:0] != '0) ||
                           (34'(erase_end) > 34'(CAPACITY_BYTES));
      valid_in = valid_ff;
      if (!req_stall) valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (!req_stall) data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;
endmodule

// ===== hw/rtl/snfcs_back.sv =====
// Back end: command sequencing state machine with a registered result.
module snfcs_back #(
   parameter longint DIE_BYTES  = 33554432,
   parameter longint PAGE_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_stall,
   input  snfcs_pkg::item_type item_data,
   input  logic [31:0]         timeout_ticks,
   input  logic                wait_forever,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output snfcs_pkg::rsp_type  rsp_data
);
   import snfcs_pkg::*;

   localparam logic [3:0] PH_IDLE = 4'd0, PH_READ = 4'd1, PH_CLEAR = 4'd2,
      PH_WREN = 4'd3, PH_WREN_ST = 4'd4, PH_CMD = 4'd5, PH_POLL = 4'd6,
      PH_POLL_WAIT = 4'd7, PH_FINAL = 4'd8;
   localparam int DW = $clog2(DIE_BYTES);

   logic [3:0]  phase_ff, phase_in;
   logic        prog_ff, prog_in;     // operation is program (else read/erase)
   logic        mut_ff, mut_in;       // operation is program or erase
   logic [25:0] addr_ff, addr_in;
   logic [26:0] left_ff, left_in;
   logic [26:0] fin_ff, fin_in;
   logic [31:0] ticks_ff, ticks_in;
   logic        att_ff, att_in;
   logic        ov_ff, ov_in;
   rsp_type     od_ff, od_in;
   logic        take, emit;
   rsp_type     r;
   logic [26:0] chunk, chunk2;
   logic [26:0] left_n;
   logic [25:0] addr_n;
   logic [DW:0] die_room, die_room2;

   function automatic rsp_type issue(logic [7:0] op, logic [25:0] a, logic ha,
                                     logic [1:0] d, logic [8:0] n);
      rsp_type x;
      x = '0;
      x.opcode = op;
      x.flash_address = ha ? a : 26'd0;
      x.has_address = ha;
      x.data_dir = d;
      x.data_length = n;
      return x;
   endfunction

   function automatic rsp_type done(logic [2:0] c, logic [26:0] b, logic a);
      rsp_type x;
      x = '0;
      x.out_kind = 1'b1;
      x.result_code = c;
      x.bytes_done = b;
      x.command_attempted = a;
      return x;
   endfunction

   // one result register; accept while it is empty or being drained
   assign item_stall = ov_ff && rsp_stall;
   assign take = item_valid && !item_stall;

   always_comb begin
      die_room = (DW+1)'(DIE_BYTES) - (DW+1)'(addr_ff[DW-1:0]);
      chunk = (left_ff < 27'(PAGE_BYTES)) ? left_ff : 27'(PAGE_BYTES);
      if (28'(die_room) < 28'(chunk)) chunk = 27'(die_room);
      left_n = left_ff - chunk;
      addr_n = addr_ff + chunk[25:0];
      die_room2 = (DW+1)'(DIE_BYTES) - (DW+1)'(addr_n[DW-1:0]);
      chunk2 = (left_n < 27'(PAGE_BYTES)) ? left_n : 27'(PAGE_BYTES);
      if (28'(die_room2) < 28'(chunk2)) chunk2 = 27'(die_room2);
   end

   always_comb begin
      phase_in = phase_ff; prog_in = prog_ff; mut_in = mut_ff;
      addr_in = addr_ff; left_in = left_ff; fin_in = fin_ff;
      ticks_in = ticks_ff; att_in = att_ff;
      emit = 1'b0; r = '0;
      if (take) begin
         case (item_data.cls)
            CLS_READ, CLS_PROG, CLS_ERASE: begin
               emit = 1'b1;
               if (phase_ff != PH_IDLE) r = done(RC_BUSY, '0, 1'b0);
               else if (item_data.cls == CLS_READ) begin
                  prog_in = 1'b0; mut_in = 1'b0; fin_in = '0;
                  if (item_data.bad_read) r = done(RC_INVALID, '0, 1'b0);
                  else if (item_data.zero_len) r = done(RC_OK, '0, 1'b0);
                  else begin
                     // no overflow: address + length fits capacity here
                     addr_in = item_data.address[25:0];
                     left_in = item_data.length[26:0];
                     phase_in = PH_READ;
                     r = issue(OPC_READ, item_data.address[25:0], 1'b1, DIR_READ,
                        9'(((item_data.length < 32'(PAGE_BYTES)) ? item_data.length
                        : 32'(PAGE_BYTES)) < 32'(DIE_BYTES -
                        longint'(item_data.address[DW-1:0])) ?
                        ((item_data.length < 32'(PAGE_BYTES)) ? item_data.length
                        : 32'(PAGE_BYTES)) : 32'(DIE_BYTES -
                        longint'(item_data.address[DW-1:0]))));
                  end
               end else begin
                  att_in = 1'b0;
                  if ((item_data.cls == CLS_PROG && item_data.bad_prog) ||
                      (item_data.cls == CLS_ERASE && item_data.bad_erase))
                     r = done(RC_INVALID, '0, 1'b0);
                  else begin
                     prog_in = (item_data.cls == CLS_PROG); mut_in = 1'b1;
                     addr_in = item_data.address[25:0];
                     left_in = prog_in ? item_data.length[26:0] : 27'd0;
                     fin_in = '0; ticks_in = '0; phase_in = PH_CLEAR;
                     r = issue(OPC_CLFSR, '0, 1'b0, DIR_NONE, '0);
                  end
               end
            end
            CLS_DONE: begin
               if (phase_ff != PH_IDLE && phase_ff != PH_POLL_WAIT) begin
                  if (!item_data.xfer_ok) begin
                     emit = 1'b1; phase_in = PH_IDLE;
                     r = done(RC_PROTO, fin_ff, mut_ff & att_ff);
                  end else begin
                     case (phase_ff)
                        PH_READ: begin
                           emit = 1'b1;
                           fin_in = fin_ff + chunk; left_in = left_n; addr_in = addr_n;
                           if (left_n == '0) begin
                              phase_in = PH_IDLE;
                              r = done(RC_OK, fin_ff + chunk, 1'b0);
                           end else
                              r = issue(OPC_READ, addr_n, 1'b1, DIR_READ, chunk2[8:0]);
                        end
                        PH_CLEAR: begin
                           emit = 1'b1; phase_in = PH_WREN;
                           r = issue(OPC_WREN, '0, 1'b0, DIR_NONE, '0);
                        end
                        PH_WREN: begin
                           emit = 1'b1; phase_in = PH_WREN_ST;
                           r = issue(OPC_RDSR, '0, 1'b0, DIR_READ, 9'd1);
                        end
                        PH_WREN_ST: begin
                           emit = 1'b1;
                           if ((item_data.reply_byte & SR_WEL) == '0) begin
                              phase_in = PH_IDLE;
                              r = done(RC_PROTO, fin_ff, mut_ff & att_ff);
                           end else begin
                              phase_in = PH_CMD; att_in = 1'b1;
                              if (prog_ff)
                                 r = issue(OPC_PROG, addr_ff, 1'b1, DIR_WRITE,
                                    left_ff[8:0]);
                              else r = issue(OPC_ERASE, addr_ff, 1'b1, DIR_NONE, '0);
                           end
                        end
                        PH_CMD: begin
                           emit = 1'b1; phase_in = PH_POLL; ticks_in = '0;
                           r = issue(OPC_RDFSR, '0, 1'b0, DIR_READ, 9'd1);
                        end
                        PH_POLL: begin
                           if ((item_data.reply_byte & FSR_READY) != '0) begin
                              emit = 1'b1;
                              if ((item_data.reply_byte & FSR_ERRORS) != '0) begin
                                 phase_in = PH_IDLE;
                                 r = done(RC_HWFAULT, fin_ff, mut_ff & att_ff);
                              end else begin
                                 phase_in = PH_FINAL;
                                 r = issue(OPC_RDSR, '0, 1'b0, DIR_READ, 9'd1);
                              end
                           end else if (!wait_forever && (timeout_ticks == '0 ||
                                        ticks_ff >= timeout_ticks)) begin
                              emit = 1'b1; phase_in = PH_IDLE;
                              r = done(RC_TIMEOUT, fin_ff, mut_ff & att_ff);
                           end else phase_in = PH_POLL_WAIT;
                        end
                        PH_FINAL: begin
                           emit = 1'b1; phase_in = PH_IDLE;
                           if ((item_data.reply_byte & SR_WEL) != '0)
                              r = done(RC_PROTO, fin_ff, mut_ff & att_ff);
                           else begin
                              if (prog_ff) fin_in = left_ff;
                              r = done(RC_OK, prog_ff ? left_ff : fin_ff,
                                 mut_ff & att_ff);
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
            CLS_TICK: begin
               if (phase_ff == PH_POLL || phase_ff == PH_POLL_WAIT) begin
                  if (ticks_ff != '1) ticks_in = ticks_ff + 32'd1;
                  if (phase_ff == PH_POLL_WAIT) begin
                     emit = 1'b1; phase_in = PH_POLL;
                     r = issue(OPC_RDFSR, '0, 1'b0, DIR_READ, 9'd1);
                  end
               end
            end
            default: ;
         endcase
      end
      ov_in = ov_ff && rsp_stall;
      od_in = od_ff;
      if (emit) begin
         ov_in = 1'b1; od_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; prog_ff <= 1'b0; mut_ff <= 1'b0;
         addr_ff <= '0; left_ff <= '0; fin_ff <= '0; ticks_ff <= '0;
         att_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; prog_ff <= prog_in; mut_ff <= mut_in;
         addr_ff <= addr_in; left_ff <= left_in; fin_ff <= fin_in;
         ticks_ff <= ticks_in; att_ff <= att_in; ov_ff <= ov_in;
      end
      od_ff <= od_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;
endmodule

// ===== hw/rtl/spi_nor_flash_command_sequencer.sv =====
// Top level of the SPI NOR command sequencer.
// Sequences four-byte-address SPI NOR reads, page programs and subsector
// erases. Each accepted transfer on req_ (request, transaction finished or
// tick) is one decision and yields at most one rsp_ transfer: a transaction
// to issue or an operation-finished report. A transfer is accepted every
// cycle while req_stall is low; it passes a one-entry front register that
// holds the precomputed range checks, then the sequencing state machine,
// whose result waits in an output register. Reads are cut into chunks of
// at most one page that never cross a die boundary. Program and erase run
// clear-flags, write-enable with WEL check, the command, flag polling on
// ticks with timeout, and a final WEL-clear check. Write csr_ registers
// only while idle: index 0 timeout_ticks, index 1 wait_forever.
module spi_nor_flash_command_sequencer #(
   parameter longint CAPACITY_BYTES  = 67108864,
   parameter longint DIE_BYTES       = 33554432,
   parameter longint PAGE_BYTES      = 256,
   parameter longint SUBSECTOR_BYTES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  snfcs_pkg::req_type_s_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output snfcs_pkg::rsp_type        rsp_data,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [31:0]               csr_data
);
   import snfcs_pkg::*;

   logic        item_valid, item_stall;
   item_type    item_data;
   logic [31:0] timeout_ff;
   logic        forever_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 32'd3000;
         forever_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == CSR_TIMEOUT) timeout_ff <= csr_data;
         if (csr_index == CSR_FOREVER) forever_ff <= csr_data[0];
      end
   end

   snfcs_front #(
      .CAPACITY_BYTES(CAPACITY_BYTES), .PAGE_BYTES(PAGE_BYTES),
      .SUBSECTOR_BYTES(SUBSECTOR_BYTES)
   ) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .item_valid, .item_stall, .item_data
   );

   snfcs_back #(.DIE_BYTES(DIE_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_back (
      .clock, .reset, .item_valid, .item_stall, .item_data,
      .timeout_ticks(timeout_ff), .wait_forever(forever_ff),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
